/* sv/hpve_pkg.sv */
`default_nettype none

package hpve_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_KEY_BYTES_DEF = 8;
	localparam int POSITION_BITS_DEF = 16;

	// Fixed field widths
	localparam int BYTE_BITS    = 8;
	localparam int KEY_LEN_BITS = 4;
	localparam int CFG_DATA_BITS = 64;
	localparam int OUT_POS_BITS = 16;

	// Characters of interest
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [31:0] HEADER_END = 32'h0D0A_0D0A;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_KEY_BYTES  = 1'b0,
		REG_KEY_LENGTH = 1'b1
	} cfg_reg_t;

	// Parser phase
	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_KEY    = 3'd1,
		PH_COLON  = 3'd2,
		PH_OPEN   = 3'd3,
		PH_VALUE  = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	// Result of one scan step
	typedef struct packed {
		logic                    emit;
		logic                    found;
		logic [OUT_POS_BITS-1:0] offset;
		logic [OUT_POS_BITS-1:0] length;
	} scan_res_t;

endpackage

`default_nettype wire

/* sv/http_post_value_extractor.sv */
// Extracts one quoted value from the body of an HTTP request.
// Input channel s_*: one request byte per item in s_tdata, s_tlast on the
// final byte; a zero byte also ends the request.
// Output channel m_*: at most one item per request. m_tuser is the found
// flag, m_tdata carries the value offset and length (both zero if not found).
// Config channel cfg_*: index 0 writes the key bytes (first character in the
// highest used byte), index 1 the key length; always ready, write only while
// no request is in flight.
// Throughput: one byte per cycle sustained while no result waits on a low
// m_tready. The per-byte work is a single pass of compares and shifts between
// the input register and the output register, and the parser state feeds
// back through its own registers. A result is registered in the output
// register that drives m_*, after its byte has passed the input register.
// Reset clears the parser to the header search and the key registers to
// zero bytes and length one. When m_tready is low with a result held, the
// input register holds its byte and s_tready drops once it is full; no
// item is lost or repeated.
`default_nettype none

module http_post_value_extractor
	import hpve_pkg::*;
#(
	parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// Request bytes
	input  wire logic                      s_tvalid,
	output      logic                      s_tready,
	input  wire logic [7:0]                s_tdata,   // [7:0] data_byte
	input  wire logic                      s_tlast,
	// Results
	output      logic                      m_tvalid,
	input  wire logic                      m_tready,
	output      logic [31:0]               m_tdata,   // [15:0] value_offset, [31:16] value_length
	output      logic                      m_tuser,   // [0] found
	// Configuration writes
	input  wire logic                      cfg_valid,
	output      logic                      cfg_ready,
	input  wire cfg_reg_t                  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int KEY_BITS = 8 * MAX_KEY_BYTES;

	logic [KEY_BITS-1:0]     key_bytes_q;
	logic [KEY_LEN_BITS-1:0] key_length_q;

	logic                 valid_s1;
	logic [BYTE_BITS-1:0] byte_s1;
	logic                 last_s1;

	logic                    m_valid_q;
	logic                    found_q;
	logic [OUT_POS_BITS-1:0] offset_q;
	logic [OUT_POS_BITS-1:0] length_q;

	logic      out_free;
	logic      advance;
	scan_res_t res;

	assign cfg_ready = 1'b1;

	// Hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_bytes_q  <= '0;
			key_length_q <= KEY_LEN_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KEY_BYTES:  key_bytes_q  <= cfg_data[KEY_BITS-1:0];
				REG_KEY_LENGTH: key_length_q <= cfg_data[KEY_LEN_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Handshake between the stages
	assign out_free = !m_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	hpve_scan #(
		.MAX_KEY_BYTES(MAX_KEY_BYTES),
		.POSITION_BITS(POSITION_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.last      (last_s1),
		.key_bytes (key_bytes_q),
		.key_length(key_length_q),
		.res       (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= res.emit;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			found_q  <= res.found;
			offset_q <= res.offset;
			length_q <= res.length;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = found_q;
	assign m_tdata  = {length_q, offset_q};

`ifndef ASSERT_OFF
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("not-found result carries a nonzero offset or length");
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_valid_q && !m_tready |=> valid_s1 && $stable(byte_s1)
			&& $stable(last_s1))
		else $error("input register changed while the output stalled");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_tready |-> !advance)
		else $error("scan step while a result is still waiting");
`endif

endmodule

`default_nettype wire

/* sv/hpve_scan.sv */
`default_nettype none

module hpve_scan
	import hpve_pkg::*;
#(
	parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic [BYTE_BITS-1:0]          data_byte,
	input  wire logic                          last,
	input  wire logic [8*MAX_KEY_BYTES-1:0]    key_bytes,
	input  wire logic [KEY_LEN_BITS-1:0]       key_length,
	output scan_res_t                          res
);

	localparam int KEY_BITS = 8 * MAX_KEY_BYTES;
	localparam int BC_BITS  = $clog2(MAX_KEY_BYTES + 1);
	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
	localparam logic [BC_BITS-1:0] BC_MAX = BC_BITS'(MAX_KEY_BYTES);
	localparam logic [KEY_LEN_BITS-1:0] LEN_MAX = KEY_LEN_BITS'(MAX_KEY_BYTES);

	logic [31:0]              header_window_q, header_window_d;
	phase_t                   phase_q, phase_d;
	logic [KEY_BITS-1:0]      key_window_q, key_window_d;
	logic [BC_BITS-1:0]       body_count_q, body_count_d;
	logic [POSITION_BITS-1:0] byte_position_q, byte_position_d;
	logic [POSITION_BITS-1:0] value_start_q, value_start_d;
	logic [POSITION_BITS-1:0] value_count_q, value_count_d;

	logic [POSITION_BITS-1:0] pos_inc;
	logic [POSITION_BITS-1:0] count_inc;
	logic [KEY_LEN_BITS-1:0]  key_len_eff;
	logic [KEY_BITS-1:0]      key_window_shift;
	logic [BC_BITS-1:0]       body_count_inc;
	logic [MAX_KEY_BYTES-1:0] byte_hit;
	logic                     key_match;
	logic [31:0]              header_shift;

	// Saturating counters
	assign pos_inc   = (byte_position_q == POS_MAX) ? POS_MAX : byte_position_q + 1'b1;
	assign count_inc = (value_count_q == POS_MAX) ? POS_MAX : value_count_q + 1'b1;

	// Clamp the key length into 1..MAX_KEY_BYTES
	always_comb begin
		if (key_length == '0) begin
			key_len_eff = KEY_LEN_BITS'(1);
		end else if (key_length > LEN_MAX) begin
			key_len_eff = LEN_MAX;
		end else begin
			key_len_eff = key_length;
		end
	end

	// Shift windows and compare the key, byte by byte
	assign header_shift     = {header_window_q[23:0], data_byte};
	assign key_window_shift = KEY_BITS'({key_window_q, data_byte});
	assign body_count_inc   = (body_count_q == BC_MAX) ? BC_MAX : body_count_q + 1'b1;

	always_comb begin
		for (int i = 0; i < MAX_KEY_BYTES; i++) begin
			byte_hit[i] = (key_window_shift[8*i +: 8] == key_bytes[8*i +: 8]) ||
				(KEY_LEN_BITS'(i) >= key_len_eff);
		end
		key_match = (&byte_hit) && (KEY_LEN_BITS'(body_count_inc) >= key_len_eff);
	end

	// Next state and result for the item in hand
	always_comb begin
		header_window_d = header_window_q;
		phase_d         = phase_q;
		key_window_d    = key_window_q;
		body_count_d    = body_count_q;
		byte_position_d = pos_inc;
		value_start_d   = value_start_q;
		value_count_d   = value_count_q;
		res             = '0;
		if (phase_q == PH_DONE) begin
			if (data_byte == CH_NUL || last) begin
				phase_d         = PH_HEADER;
				header_window_d = '0;
				key_window_d    = '0;
				body_count_d    = '0;
				byte_position_d = '0;
				value_start_d   = '0;
				value_count_d   = '0;
			end
		end else if (data_byte == CH_NUL) begin
			res.emit        = 1'b1;
			phase_d         = PH_HEADER;
			header_window_d = '0;
			key_window_d    = '0;
			body_count_d    = '0;
			byte_position_d = '0;
			value_start_d   = '0;
			value_count_d   = '0;
		end else begin
			case (phase_q)
				PH_HEADER: begin
					header_window_d = header_shift;
					if (header_shift == HEADER_END) begin
						phase_d = PH_KEY;
					end
				end
				PH_KEY: begin
					key_window_d = key_window_shift;
					body_count_d = body_count_inc;
					if (key_match) begin
						phase_d = PH_COLON;
					end
				end
				PH_COLON: begin
					if (data_byte == CH_COLON) begin
						phase_d = PH_OPEN;
					end
				end
				PH_OPEN: begin
					if (data_byte == CH_QUOTE) begin
						phase_d       = PH_VALUE;
						value_start_d = pos_inc;
						value_count_d = '0;
					end
				end
				PH_VALUE: begin
					if (data_byte == CH_QUOTE) begin
						res.found = 1'b1;
						res.offset = OUT_POS_BITS'(value_start_q);
						res.length = OUT_POS_BITS'(value_count_q);
						phase_d    = PH_DONE;
					end else begin
						value_count_d = count_inc;
					end
				end
				default: begin
				end
			endcase
			if (last) begin
				res.emit        = 1'b1;
				phase_d         = PH_HEADER;
				header_window_d = '0;
				key_window_d    = '0;
				body_count_d    = '0;
				byte_position_d = '0;
				value_start_d   = '0;
				value_count_d   = '0;
			end
			// A closing quote reports the value even on the final byte
			if (res.found) begin
				res.emit = 1'b1;
			end
		end
	end

	// Advance the state on each processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_window_q <= '0;
			phase_q         <= PH_HEADER;
			key_window_q    <= '0;
			body_count_q    <= '0;
			byte_position_q <= '0;
			value_start_q   <= '0;
			value_count_q   <= '0;
		end else if (step) begin
			header_window_q <= header_window_d;
			phase_q         <= phase_d;
			key_window_q    <= key_window_d;
			body_count_q    <= body_count_d;
			byte_position_q <= byte_position_d;
			value_start_q   <= value_start_d;
			value_count_q   <= value_count_d;
		end
	end

`ifndef ASSERT_OFF
	a_found_from_value: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.found |-> phase_q == PH_VALUE && data_byte == CH_QUOTE)
		else $error("value reported outside the value phase");
	a_miss_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.emit && !res.found |=> phase_q == PH_HEADER && byte_position_q == '0)
		else $error("not-found result did not restart the request");
	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_DONE |-> !res.emit)
		else $error("result after the value was already reported");
`endif

endmodule

`default_nettype wire
